[rtl/ace_pkg.sv]
`default_nettype none
package ace_pkg;

	localparam int MaxColumns = 4096;
	localparam int FifoDepth = 8;

	localparam logic [7:0] GapSymbol = 8'd45;

	typedef enum logic [1:0] {
		KIND_MATCH = 2'd0,
		KIND_INS   = 2'd1,
		KIND_DEL   = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] read_symbol;
		logic [7:0] ref_symbol;
		logic       last_column;
	} in_beat_t;

	typedef struct packed {
		logic [12:0] run_length;
		logic [1:0]  run_kind;
		logic [12:0] match_score;
		logic        final_run;
	} out_beat_t;

	typedef struct packed {
		kind_t kind;
		logic  identical;
		logic  last;
	} column_t;

	typedef struct packed {
		logic      en0;
		out_beat_t data0;
		logic      en1;
		out_beat_t data1;
	} push_t;

endpackage
`default_nettype wire

[rtl/alignment_cigar_run_encoder.sv]
// Run-length encoder for the columns of a gapped pairwise alignment.
// The input channel takes one column per beat: read symbol, reference symbol
// and a last flag. The output channel gives one CIGAR run per beat with its
// length, kind, and on the final run of an alignment the total match score.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low.
// A column is taken every cycle while the input is not stalled. It is
// registered, classified and merged into the open run in the next cycle, and
// any finished runs are written into an eight-entry output queue. A column
// may finish up to two runs; the queue drains one run per cycle while the
// output is not stalled.
// The input stalls while the queue lacks room for the runs that the column in
// flight and one more could produce, so a stalled output fills the queue and
// then holds the input back with no run lost.
// Reset empties the queue, drops the column in flight and leaves no run open.
`default_nettype none
module alignment_cigar_run_encoder #(
	parameter int MAX_COLUMNS = ace_pkg::MaxColumns
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire ace_pkg::in_beat_t  in_beat,
	output logic                    out_valid,
	input  wire                     out_stall,
	output ace_pkg::out_beat_t      out_beat
);

	localparam int Depth = ace_pkg::FifoDepth;
	localparam int NW = $clog2(Depth + 1);

	logic              valid_s1;
	ace_pkg::in_beat_t beat_s1;
	ace_pkg::column_t  column;
	ace_pkg::push_t    push;
	logic [NW-1:0]     fifo_count;
	logic [NW:0]       reserved;

	assign reserved = {1'b0, fifo_count} + (valid_s1 ? (NW+1)'(2) : '0);
	assign in_stall = (reserved > (NW+1)'(Depth - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_beat;
		end
	end

	ace_classify u_classify (
		.beat   (beat_s1),
		.column (column)
	);

	ace_run #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.column (column),
		.push   (push)
	);

	ace_fifo #(
		.DEPTH (Depth)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_valid && !out_stall),
		.head      (out_beat),
		.not_empty (out_valid),
		.count     (fifo_count)
	);

endmodule
`default_nettype wire

[rtl/ace_classify.sv]
`default_nettype none
module ace_classify (
	input  wire ace_pkg::in_beat_t beat,
	output ace_pkg::column_t       column
);

	always_comb begin
		column.identical = 1'b0;
		column.last = beat.last_column;
		priority if (beat.read_symbol == ace_pkg::GapSymbol) begin
			column.kind = ace_pkg::KIND_DEL;
		end else if (beat.ref_symbol == ace_pkg::GapSymbol) begin
			column.kind = ace_pkg::KIND_INS;
		end else begin
			column.kind = ace_pkg::KIND_MATCH;
			column.identical = (beat.read_symbol == beat.ref_symbol);
		end
	end

endmodule
`default_nettype wire

[rtl/ace_run.sv]
`default_nettype none
module ace_run #(
	parameter int MAX_COLUMNS = ace_pkg::MaxColumns
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   valid,
	input  wire ace_pkg::column_t column,
	output ace_pkg::push_t        push
);

	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam logic [CW-1:0] Limit = CW'(MAX_COLUMNS);

	ace_pkg::kind_t kind_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  score_q;

	logic          cont;
	logic          flush_old;
	logic [CW-1:0] run_cnt;
	logic [CW-1:0] score_nx;
	ace_pkg::out_beat_t old_run;
	ace_pkg::out_beat_t fin_run;

	always_comb begin
		score_nx = score_q;
		if (column.kind == ace_pkg::KIND_MATCH && column.identical) begin
			score_nx = (score_q >= Limit) ? Limit : score_q + 1'b1;
		end
		cont = (kind_q == column.kind) && (count_q != '0);
		flush_old = !cont && (kind_q != ace_pkg::KIND_NONE) && (count_q != '0);
		if (cont) begin
			run_cnt = (count_q >= Limit) ? Limit : count_q + 1'b1;
		end else begin
			run_cnt = CW'(1);
		end

		old_run.run_length = 13'(count_q);
		old_run.run_kind = kind_q;
		old_run.match_score = '0;
		old_run.final_run = 1'b0;

		fin_run.run_length = 13'(run_cnt);
		fin_run.run_kind = column.kind;
		fin_run.match_score = 13'(score_nx);
		fin_run.final_run = 1'b1;

		if (flush_old) begin
			push.en0 = valid;
			push.data0 = old_run;
			push.en1 = valid && column.last;
		end else begin
			push.en0 = valid && column.last;
			push.data0 = fin_run;
			push.en1 = 1'b0;
		end
		push.data1 = fin_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= ace_pkg::KIND_NONE;
			count_q <= '0;
			score_q <= '0;
		end else if (valid) begin
			if (column.last) begin
				kind_q <= ace_pkg::KIND_NONE;
				count_q <= '0;
				score_q <= '0;
			end else begin
				kind_q <= column.kind;
				count_q <= run_cnt;
				score_q <= score_nx;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/ace_fifo.sv]
`default_nettype none
module ace_fifo #(
	parameter int DEPTH = ace_pkg::FifoDepth
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire ace_pkg::push_t     push,
	input  wire                     pop,
	output ace_pkg::out_beat_t      head,
	output logic                    not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	ace_pkg::out_beat_t mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [NW-1:0] count_q;
	logic [NW-1:0] push_n;

	assign head = mem_q[rd_q];
	assign not_empty = (count_q != '0);
	assign count = count_q;
	assign push_n = NW'(push.en0) + NW'(push.en1);

	always_ff @(posedge clk) begin
		if (push.en0) begin
			mem_q[wr_q] <= push.data0;
		end
		if (push.en1) begin
			mem_q[wr_q + 1'b1] <= push.data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + AW'(push_n);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			count_q <= count_q + push_n - NW'(pop);
		end
	end

endmodule
`default_nettype wire

[sim/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 2000;
	localparam int RandomColumns = 630;
	localparam int SqueezeAfter = 200;
	localparam int SqueezeCycles = 200;
	localparam logic [7:0] SymA = "A";
	localparam logic [7:0] SymC = "C";
	localparam logic [7:0] SymG = "G";

	typedef struct {
		ace_pkg::in_beat_t  col;
		int                 reps;
		int                 n_fixed;
		ace_pkg::out_beat_t fixed0;
		ace_pkg::out_beat_t fixed1;
	} script_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	ace_pkg::in_beat_t  in_beat;
	logic               out_valid;
	logic               out_stall;
	ace_pkg::out_beat_t out_beat;

	script_row_t        script[$];
	ace_pkg::out_beat_t run_log[$];

	ace_pkg::kind_t open_kind;
	int             open_count;
	int             score_total;

	bit failed;
	bit quiet_in;
	bit quiet_out;
	bit squeeze_done;
	int random_sent;
	int idle_cycles;

	alignment_cigar_run_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic ace_pkg::out_beat_t make_run(int len, ace_pkg::kind_t k, int sc,
			bit fin);
		ace_pkg::out_beat_t r;
		r.run_length = len[12:0];
		r.run_kind = k;
		r.match_score = sc[12:0];
		r.final_run = fin;
		return r;
	endfunction

	function automatic int sat_up(int v);
		return (v >= ace_pkg::MaxColumns) ? ace_pkg::MaxColumns : v + 1;
	endfunction

	function automatic void queue_run(ace_pkg::out_beat_t r);
		run_log = {run_log, r};
	endfunction

	function automatic int encode_column(input ace_pkg::in_beat_t b,
			output ace_pkg::out_beat_t r0, output ace_pkg::out_beat_t r1);
		ace_pkg::kind_t     k;
		int                 n;
		ace_pkg::out_beat_t runs[2];
		n = 0;
		runs[0] = '0;
		runs[1] = '0;
		if (b.read_symbol == ace_pkg::GapSymbol) begin
			k = ace_pkg::KIND_DEL;
		end else if (b.ref_symbol == ace_pkg::GapSymbol) begin
			k = ace_pkg::KIND_INS;
		end else begin
			k = ace_pkg::KIND_MATCH;
			if (b.read_symbol == b.ref_symbol) begin
				score_total = sat_up(score_total);
			end
		end
		if (open_kind == k && open_count > 0) begin
			open_count = sat_up(open_count);
		end else begin
			if (open_kind != ace_pkg::KIND_NONE && open_count > 0) begin
				runs[n] = make_run(open_count, open_kind, 0, 1'b0);
				n++;
			end
			open_kind = k;
			open_count = 1;
		end
		if (b.last_column) begin
			runs[n] = make_run(open_count, open_kind, score_total, 1'b1);
			n++;
			open_kind = ace_pkg::KIND_NONE;
			open_count = 0;
			score_total = 0;
		end
		r0 = runs[0];
		r1 = runs[1];
		return n;
	endfunction

	function automatic void add_row(logic [7:0] rd, logic [7:0] rf, bit last, int reps,
			int n_fixed, ace_pkg::out_beat_t f0, ace_pkg::out_beat_t f1);
		script_row_t row;
		row.col.read_symbol = rd;
		row.col.ref_symbol = rf;
		row.col.last_column = last;
		row.reps = reps;
		row.n_fixed = n_fixed;
		row.fixed0 = f0;
		row.fixed1 = f1;
		script = {script, row};
	endfunction

	function automatic logic [7:0] plain_symbol();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == ace_pkg::GapSymbol);
		return v;
	endfunction

	// A negative n_fixed means the runs come from the predictor alone.
	task automatic send_column(ace_pkg::in_beat_t b, int n_fixed, ace_pkg::out_beat_t f0,
			ace_pkg::out_beat_t f1);
		int                 gap;
		int                 got;
		ace_pkg::out_beat_t p0;
		ace_pkg::out_beat_t p1;
		if ($urandom_range(0, 29) == 0) quiet_in = !quiet_in;
		gap = quiet_in ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_beat <= b;
		do @(posedge clk); while (in_stall);
		got = encode_column(b, p0, p1);
		if (n_fixed < 0) begin
			if (got > 0) queue_run(p0);
			if (got > 1) queue_run(p1);
		end else begin
			if (n_fixed > 0) queue_run(f0);
			if (n_fixed > 1) queue_run(f1);
		end
	endtask

	task automatic check_field(string name, int want, int seen);
		if (want != seen) begin
			$error("%s: expected %0d, actual %0d", name, want, seen);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		ace_pkg::out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (run_log.size() == 0) begin
				$error("run beat with nothing expected: length %0d kind %0d",
					out_beat.run_length, out_beat.run_kind);
				failed = 1'b1;
			end else begin
				want = run_log.pop_front();
				check_field("run_length", want.run_length, out_beat.run_length);
				check_field("run_kind", want.run_kind, out_beat.run_kind);
				check_field("match_score", want.match_score, out_beat.match_score);
				check_field("final_run", want.final_run, out_beat.final_run);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WatchdogLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver holds off once for a long stretch so that the output queue fills
	// and the input is stalled.
	initial begin
		int hold;
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
			hold = quiet_out ? 0 : $urandom_range(0, 5);
			if (!squeeze_done && random_sent >= SqueezeAfter) begin
				hold = SqueezeCycles;
				squeeze_done = 1'b1;
			end
			if (hold > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		int                len;
		int                run_left;
		int                pick;
		ace_pkg::in_beat_t b;
		ace_pkg::kind_t    k;
		in_valid = 1'b0;
		in_beat = '0;
		arst_n = 1'b0;
		failed = 1'b0;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		squeeze_done = 1'b0;
		random_sent = 0;
		idle_cycles = 0;
		open_kind = ace_pkg::KIND_NONE;
		open_count = 0;
		score_total = 0;
		run_left = 0;
		k = ace_pkg::KIND_MATCH;

		add_row(SymA, SymA, 1, 1, 1, make_run(1, ace_pkg::KIND_MATCH, 1, 1), '0);
		add_row(SymA, SymC, 1, 1, 1, make_run(1, ace_pkg::KIND_MATCH, 0, 1), '0);
		add_row(ace_pkg::GapSymbol, SymC, 1, 1, 1, make_run(1, ace_pkg::KIND_DEL, 0, 1), '0);
		add_row(SymA, ace_pkg::GapSymbol, 1, 1, 1, make_run(1, ace_pkg::KIND_INS, 0, 1), '0);
		// Both symbols are gaps, which counts as a deletion.
		add_row(ace_pkg::GapSymbol, ace_pkg::GapSymbol, 1, 1, 1,
			make_run(1, ace_pkg::KIND_DEL, 0, 1), '0);
		add_row(8'h00, 8'h00, 0, 1, 0, '0, '0);
		add_row(8'hff, 8'hff, 0, 1, 0, '0, '0);
		add_row(8'hff, 8'h00, 0, 1, 0, '0, '0);
		add_row(8'h00, ace_pkg::GapSymbol, 0, 1, 1, make_run(3, ace_pkg::KIND_MATCH, 0, 0), '0);
		add_row(8'hff, ace_pkg::GapSymbol, 0, 1, 0, '0, '0);
		// A change of kind on the last column gives two runs.
		add_row(ace_pkg::GapSymbol, 8'h00, 1, 1, 2, make_run(2, ace_pkg::KIND_INS, 0, 0),
			make_run(1, ace_pkg::KIND_DEL, 2, 1));
		add_row(ace_pkg::GapSymbol, ace_pkg::GapSymbol, 0, 1, 0, '0, '0);
		add_row(ace_pkg::GapSymbol, 8'hff, 0, 1, 0, '0, '0);
		add_row(SymG, SymG, 1, 1, 2, make_run(2, ace_pkg::KIND_DEL, 0, 0),
			make_run(1, ace_pkg::KIND_MATCH, 1, 1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			for (int j = 0; j < script[i].reps; j++) begin
				send_column(script[i].col, (j == script[i].reps - 1) ? script[i].n_fixed : -1,
					script[i].fixed0, script[i].fixed1);
			end
		end

		// Random alignments built from runs of one kind, with some noise columns.
		while (random_sent < RandomColumns) begin
			len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
			for (int j = 0; j < len; j++) begin
				if (run_left == 0) begin
					pick = $urandom_range(0, 9);
					k = (pick < 6) ? ace_pkg::KIND_MATCH :
						(pick < 8) ? ace_pkg::KIND_INS : ace_pkg::KIND_DEL;
					run_left = $urandom_range(1, 8);
				end
				run_left--;
				if ($urandom_range(0, 9) == 0) begin
					b.read_symbol = 8'($urandom_range(0, 255));
					b.ref_symbol = 8'($urandom_range(0, 255));
				end else if (k == ace_pkg::KIND_MATCH) begin
					b.read_symbol = plain_symbol();
					b.ref_symbol = ($urandom_range(0, 9) < 7) ? b.read_symbol : plain_symbol();
				end else if (k == ace_pkg::KIND_INS) begin
					b.read_symbol = plain_symbol();
					b.ref_symbol = ace_pkg::GapSymbol;
				end else begin
					b.read_symbol = ace_pkg::GapSymbol;
					b.ref_symbol = ($urandom_range(0, 3) == 0) ? ace_pkg::GapSymbol :
						8'($urandom_range(0, 255));
				end
				b.last_column = (j == len - 1);
				send_column(b, -1, '0, '0);
				random_sent++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (run_log.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (!failed) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/ace_pkg.sv
rtl/ace_classify.sv
rtl/ace_run.sv
rtl/ace_fifo.sv
rtl/alignment_cigar_run_encoder.sv
sim/tb.sv
